FILE: rtl/otp_white_balance_gain_calc_top_defines.svh
// Assertion macros for the white balance gain calculator.
// Included by the files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef OTP_WHITE_BALANCE_GAIN_CALC_TOP_DEFINES_SVH
`define OTP_WHITE_BALANCE_GAIN_CALC_TOP_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define WBGC_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("wbgc same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define WBGC_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("wbgc next-cycle check failed");

`endif

FILE: rtl/wbgc_pkg.sv
// Shared types and constants of the white balance gain calculator.
// Used by wbgc_cell, wbgc_row and the top level; depends on nothing.
package wbgc_pkg;

  localparam int MEAS_W  = 16;
  localparam int GOLD_W  = 10;
  localparam int GAIN_W  = 16;
  localparam int RATIO_W = 19;            // 512 * 1023 fits in 19 bits
  localparam int DQ_W    = 27;            // widest dividend: 256 * ratio
  localparam int REM_W   = RATIO_W;       // remainder stays below divisor
  localparam int DIV_STEPS = DQ_W;        // one quotient bit per cell
  localparam int LANES   = 4;

  // Lane use in the first row
  localparam int LN_RR = 0;
  localparam int LN_BR = 1;
  // Lane use in the second row
  localparam int LN_GR    = 0;
  localparam int LN_GB    = 1;
  localparam int LN_BR_RR = 2;
  localparam int LN_RR_BR = 3;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(512);
  localparam logic [GAIN_W-1:0]  UNIT_GAIN = GAIN_W'(256);
  localparam logic [DQ_W-1:0]    GREEN_NUM = DQ_W'(256 * 512);
  localparam logic [GOLD_W-1:0]  GOLD_RESET = GOLD_W'(631);

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_NO_UPDATE = 2'd1,
    ST_DIV_ZERO  = 2'd2
  } status_t;

  typedef enum logic {
    REG_GOLDEN_RG = 1'b0,
    REG_GOLDEN_BG = 1'b1
  } reg_idx_t;

  // One divider lane: partial remainder, dividend/quotient shift word, divisor
  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [DQ_W-1:0]    dq;
    logic [RATIO_W-1:0] dsr;
  } div_t;

  typedef struct packed {
    status_t           status;
    logic              ge_r;
    logic              ge_b;
    logic [GAIN_W-1:0] half_r;
    logic [GAIN_W-1:0] half_b;
  } side_t;

  typedef struct packed {
    side_t                 side;
    div_t [LANES-1:0]      lane;
  } payload_t;

endpackage

FILE: rtl/wbgc_cell.sv
// One pipeline cell: a restoring division step on every lane, registered.
// Depends on wbgc_pkg.
module wbgc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               d_vld,
  input  wbgc_pkg::payload_t d,
  output logic               q_vld,
  output wbgc_pkg::payload_t q
);

  logic               vld_r;
  wbgc_pkg::payload_t data_r;
  wbgc_pkg::payload_t data_nxt;

  // Shift in the next dividend bit, subtract the divisor when it fits
  function automatic wbgc_pkg::div_t div_step(wbgc_pkg::div_t x);
    logic [wbgc_pkg::REM_W:0] trial;
    logic [wbgc_pkg::REM_W:0] dsr_ext;
    wbgc_pkg::div_t           y;
    trial   = {x.rem, x.dq[wbgc_pkg::DQ_W-1]};
    dsr_ext = {1'b0, x.dsr};
    y       = x;
    if (trial >= dsr_ext) begin
      y.rem = wbgc_pkg::REM_W'(trial - dsr_ext);
      y.dq  = {x.dq[wbgc_pkg::DQ_W-2:0], 1'b1};
    end else begin
      y.rem = trial[wbgc_pkg::REM_W-1:0];
      y.dq  = {x.dq[wbgc_pkg::DQ_W-2:0], 1'b0};
    end
    return y;
  endfunction

  always_comb begin
    data_nxt = d;
    for (int k = 0; k < wbgc_pkg::LANES; k++) begin
      data_nxt.lane[k] = div_step(d.lane[k]);
    end
  end

  // Advance valid only when the pipeline moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign q_vld = vld_r;
  assign q     = data_r;

endmodule

FILE: rtl/wbgc_row.sv
// A row of division cells, one quotient bit per cell, all lanes in step.
// Depends on wbgc_pkg and wbgc_cell.
module wbgc_row (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               d_vld,
  input  wbgc_pkg::payload_t d,
  output logic               q_vld,
  output wbgc_pkg::payload_t q
);

  logic               vld_c  [0:wbgc_pkg::DIV_STEPS];
  wbgc_pkg::payload_t data_c [0:wbgc_pkg::DIV_STEPS];

  assign vld_c[0]  = d_vld;
  assign data_c[0] = d;

  // Chain the cells, each handing its word to the next
  for (genvar i = 0; i < wbgc_pkg::DIV_STEPS; i++) begin : g_cell
    wbgc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_vld (vld_c[i]),
      .d     (data_c[i]),
      .q_vld (vld_c[i+1]),
      .q     (data_c[i+1])
    );
  end

  assign q_vld = vld_c[wbgc_pkg::DIV_STEPS];
  assign q     = data_c[wbgc_pkg::DIV_STEPS];

endmodule

FILE: rtl/otp_white_balance_gain_calc_top.sv
// White balance gain calculator: takes measured R/Gr and B/Gb ratios and golden
// references, returns red, green and blue gains with 256 as unity and a status.
// It accepts one request per clock while the output is not stalled and returns one result
// per request in order, through two rows of 27 division cells (ratios, then gains) and
// the output register. A stalled output freezes the whole pipeline.
// Depends on wbgc_pkg, wbgc_row and the assertion macro header.
`include "otp_white_balance_gain_calc_top_defines.svh"

module otp_white_balance_gain_calc_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // measured_rg [15:0], measured_bg [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // gain_status [1:0], red_gain [17:2],
                                  // green_gain [33:18], blue_gain [49:34], zero pad
);

  logic [wbgc_pkg::GOLD_W-1:0] golden_rg_r;
  logic [wbgc_pkg::GOLD_W-1:0] golden_bg_r;
  logic [wbgc_pkg::MEAS_W-1:0] meas_rg;
  logic [wbgc_pkg::MEAS_W-1:0] meas_bg;
  logic                        adv;

  logic               a_in_vld, a_out_vld, b_out_vld;
  wbgc_pkg::payload_t a_in, a_out, b_in, b_out;

  logic [wbgc_pkg::RATIO_W-1:0] rr, br;
  logic                         pin_red;
  wbgc_pkg::status_t            status_nxt;
  logic [wbgc_pkg::GAIN_W-1:0]  red_nxt, green_nxt, blue_nxt;

  logic                         out_valid_r;
  wbgc_pkg::status_t            status_r;
  logic [wbgc_pkg::GAIN_W-1:0]  red_r, green_r, blue_r;

  // Write golden references
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      golden_rg_r <= wbgc_pkg::GOLD_RESET;
      golden_bg_r <= wbgc_pkg::GOLD_RESET;
    end else if (cfg_wr_en) begin
      case (wbgc_pkg::reg_idx_t'(cfg_addr))
        wbgc_pkg::REG_GOLDEN_RG: golden_rg_r <= cfg_wdata;
        wbgc_pkg::REG_GOLDEN_BG: golden_bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Move the pipeline whenever the output slot is free or being drained
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign meas_rg = in_tdata[15:0];
  assign meas_bg = in_tdata[31:16];

  // Load ratio divisions: 512 * golden / measured
  always_comb begin
    a_in_vld = in_tvalid;
    a_in     = '0;
    a_in.lane[wbgc_pkg::LN_RR].dq  = {8'b0, golden_rg_r, 9'b0};
    a_in.lane[wbgc_pkg::LN_RR].dsr = {3'b0, meas_rg};
    a_in.lane[wbgc_pkg::LN_BR].dq  = {8'b0, golden_bg_r, 9'b0};
    a_in.lane[wbgc_pkg::LN_BR].dsr = {3'b0, meas_bg};
    if (meas_rg == '0 || meas_bg == '0) begin
      a_in.side.status = wbgc_pkg::ST_DIV_ZERO;
    end else begin
      a_in.side.status = wbgc_pkg::ST_VALID;
    end
  end

  wbgc_row u_row_ratio (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_vld (a_in_vld),
    .d     (a_in),
    .q_vld (a_out_vld),
    .q     (a_out)
  );

  assign rr = a_out.lane[wbgc_pkg::LN_RR].dq[wbgc_pkg::RATIO_W-1:0];
  assign br = a_out.lane[wbgc_pkg::LN_BR].dq[wbgc_pkg::RATIO_W-1:0];

  // Load gain divisions: both green candidates and both cross ratios
  always_comb begin
    b_in = '0;
    b_in.lane[wbgc_pkg::LN_GR].dq     = wbgc_pkg::GREEN_NUM;
    b_in.lane[wbgc_pkg::LN_GR].dsr    = rr;
    b_in.lane[wbgc_pkg::LN_GB].dq     = wbgc_pkg::GREEN_NUM;
    b_in.lane[wbgc_pkg::LN_GB].dsr    = br;
    b_in.lane[wbgc_pkg::LN_BR_RR].dq  = {br, 8'b0};
    b_in.lane[wbgc_pkg::LN_BR_RR].dsr = rr;
    b_in.lane[wbgc_pkg::LN_RR_BR].dq  = {rr, 8'b0};
    b_in.lane[wbgc_pkg::LN_RR_BR].dsr = br;
    b_in.side.ge_r   = (rr >= wbgc_pkg::RATIO_ONE);
    b_in.side.ge_b   = (br >= wbgc_pkg::RATIO_ONE);
    b_in.side.half_r = rr[wbgc_pkg::GAIN_W:1];
    b_in.side.half_b = br[wbgc_pkg::GAIN_W:1];
    if (a_out.side.status == wbgc_pkg::ST_DIV_ZERO) begin
      b_in.side.status = wbgc_pkg::ST_DIV_ZERO;
    end else if (rr == '0 || br == '0) begin
      b_in.side.status = wbgc_pkg::ST_NO_UPDATE;
    end else begin
      b_in.side.status = wbgc_pkg::ST_VALID;
    end
  end

  wbgc_row u_row_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .d_vld (a_out_vld),
    .d     (b_in),
    .q_vld (b_out_vld),
    .q     (b_out)
  );

  // Pick the branch and pin the channel that needs the least gain
  always_comb begin
    if (b_out.side.ge_r) begin
      pin_red = 1'b0;
    end else if (b_out.side.ge_b) begin
      pin_red = 1'b1;
    end else begin
      pin_red = (b_out.lane[wbgc_pkg::LN_GR].dq >= b_out.lane[wbgc_pkg::LN_GB].dq);
    end
    status_nxt = b_out.side.status;
    if (b_out.side.status != wbgc_pkg::ST_VALID) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else if (b_out.side.ge_r && b_out.side.ge_b) begin
      red_nxt   = b_out.side.half_r;
      green_nxt = wbgc_pkg::UNIT_GAIN;
      blue_nxt  = b_out.side.half_b;
    end else if (pin_red) begin
      red_nxt   = wbgc_pkg::UNIT_GAIN;
      green_nxt = b_out.lane[wbgc_pkg::LN_GR].dq[wbgc_pkg::GAIN_W-1:0];
      blue_nxt  = b_out.lane[wbgc_pkg::LN_BR_RR].dq[wbgc_pkg::GAIN_W-1:0];
    end else begin
      red_nxt   = b_out.lane[wbgc_pkg::LN_RR_BR].dq[wbgc_pkg::GAIN_W-1:0];
      green_nxt = b_out.lane[wbgc_pkg::LN_GB].dq[wbgc_pkg::GAIN_W-1:0];
      blue_nxt  = wbgc_pkg::UNIT_GAIN;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_out_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, blue_r, green_r, red_r, status_r};

  `WBGC_ASSERT_NOW(a_no_code3, out_valid_r, status_r != 2'd3)
  `WBGC_ASSERT_NOW(a_zero_gains, out_valid_r && status_r != wbgc_pkg::ST_VALID,
                   red_r == '0 && green_r == '0 && blue_r == '0)
  `WBGC_ASSERT_NOW(a_unit_pinned, out_valid_r && status_r == wbgc_pkg::ST_VALID,
                   red_r == wbgc_pkg::UNIT_GAIN || green_r == wbgc_pkg::UNIT_GAIN ||
                   blue_r == wbgc_pkg::UNIT_GAIN)
  `WBGC_ASSERT_NEXT(a_freeze, !adv, $stable(a_out) && $stable(b_out) && $stable(b_out_vld))

endmodule

FILE: dv/tb_otp_white_balance_gain_calc_top.sv
// Testbench for the white balance gain calculator: drives ratio pairs and golden settings,
// predicts status and gains per request and checks every result in order.
// Depends on wbgc_pkg and the otp_white_balance_gain_calc_top RTL.
module tb_otp_white_balance_gain_calc_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    wbgc_pkg::status_t status;
    logic [15:0]       red;
    logic [15:0]       green;
    logic [15:0]       blue;
  } gains_t;

  // Golden-ratio gain predictor and in-order store of expected gains
  class gain_board;
    logic [9:0] gold_rg = 10'd631;
    logic [9:0] gold_bg = 10'd631;
    gains_t pending[$];
    int errors = 0;

    function gains_t calc_gains(logic [15:0] mrg, logic [15:0] mbg);
      longint unsigned rr, br, rg, gg, bg;
      bit pin_red;
      gains_t g;
      g = '{wbgc_pkg::ST_VALID, 16'd0, 16'd0, 16'd0};
      if (mrg == 0 || mbg == 0) begin
        g.status = wbgc_pkg::ST_DIV_ZERO;
        return g;
      end
      rr = (512 * longint'(gold_rg)) / mrg;
      br = (512 * longint'(gold_bg)) / mbg;
      if (rr == 0 || br == 0) begin
        g.status = wbgc_pkg::ST_NO_UPDATE;
        return g;
      end
      if (rr >= 512 && br >= 512) begin
        rg = 256 * rr / 512;
        gg = 256;
        bg = 256 * br / 512;
      end else begin
        if (rr >= 512) pin_red = 0;
        else if (br >= 512) pin_red = 1;
        else pin_red = (256 * 512 / rr) >= (256 * 512 / br);
        if (pin_red) begin
          rg = 256;
          gg = 256 * 512 / rr;
          bg = 256 * br / rr;
        end else begin
          rg = 256 * rr / br;
          gg = 256 * 512 / br;
          bg = 256;
        end
      end
      g.red = rg[15:0];
      g.green = gg[15:0];
      g.blue = bg[15:0];
      return g;
    endfunction

    function void note_request(logic [31:0] data);
      pending.push_back(calc_gains(data[15:0], data[31:16]));
    endfunction

    function void check_result(logic [55:0] data);
      gains_t got, want;
      got = '{wbgc_pkg::status_t'(data[1:0]), data[17:2], data[33:18], data[49:34]};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", data);
        return;
      end
      want = pending.pop_front();
      if (got !== want || data[55:50] !== 6'd0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st=%0d r=%h g=%h b=%h  got st=%0d r=%h g=%h b=%h",
                   want.status, want.red, want.green, want.blue,
                   got.status, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic cfg_addr = 0;
  logic [9:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [55:0] out_tdata;

  int send_idle_pct = 8;
  int recv_idle_pct = 62;
  gain_board board = new();

  otp_white_balance_gain_calc_top DUT (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  // Collect results, stalling the receiver at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Write one register, then drop the write enable again before returning
  task automatic write_golden(wbgc_pkg::reg_idx_t idx, logic [9:0] val);
    cfg_wr_en <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    if (idx == wbgc_pkg::REG_GOLDEN_RG) board.gold_rg = val;
    else board.gold_bg = val;
    @(posedge clk);
  endtask

  // Drain all results, then let the pipeline settle
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic send_request(logic [15:0] mrg, logic [15:0] mbg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {mbg, mrg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request({mbg, mrg});
  endtask

  task automatic idle_sender();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  // Mostly near-golden ratios so every gain branch is reached
  function automatic logic [15:0] pick_meas(logic [9:0] gold);
    int k;
    k = $urandom_range(99);
    if (k < 4) return 16'd0;
    if (k < 10) return 16'($urandom);
    if (k < 14) return 16'hffff;
    return 16'($urandom_range(gold * 2 + 1, gold / 2 + 1));
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_request(pick_meas(board.gold_rg), pick_meas(board.gold_bg));
    idle_sender();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: zero measures, extremes, all four gain branches
    send_request(16'd0, 16'd631);
    send_request(16'd631, 16'd0);
    send_request(16'd0, 16'd0);
    send_request(16'hffff, 16'd631);
    send_request(16'd631, 16'hffff);
    send_request(16'd1, 16'd1);
    send_request(16'd631, 16'd631);
    send_request(16'd500, 16'd400);
    send_request(16'd500, 16'd900);
    send_request(16'd900, 16'd500);
    send_request(16'd700, 16'd900);
    send_request(16'd900, 16'd700);
    send_request(16'd800, 16'd800);
    send_request(16'haaaa, 16'h5555);
    send_request(16'h5555, 16'haaaa);
    idle_sender();
    // Hold the sender until every result is back
    drain();

    // Golden extremes, including zero
    write_golden(wbgc_pkg::REG_GOLDEN_RG, 10'd1);
    write_golden(wbgc_pkg::REG_GOLDEN_BG, 10'd1023);
    send_request(16'd1, 16'd1);
    send_request(16'd512, 16'd1023);
    send_request(16'd513, 16'd2);
    send_request(16'd1, 16'hffff);
    idle_sender();
    drain();
    write_golden(wbgc_pkg::REG_GOLDEN_RG, 10'd0);
    write_golden(wbgc_pkg::REG_GOLDEN_BG, 10'd0);
    send_request(16'd5, 16'd7);
    idle_sender();
    drain();

    write_golden(wbgc_pkg::REG_GOLDEN_RG, 10'd631);
    write_golden(wbgc_pkg::REG_GOLDEN_BG, 10'd631);
    random_phase(650);
    drain();

    send_idle_pct = 62;
    recv_idle_pct = 8;
    write_golden(wbgc_pkg::REG_GOLDEN_RG, 10'($urandom_range(1023, 1)));
    write_golden(wbgc_pkg::REG_GOLDEN_BG, 10'($urandom_range(1023, 1)));
    random_phase(650);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_golden(wbgc_pkg::REG_GOLDEN_RG, 10'd1023);
    write_golden(wbgc_pkg::REG_GOLDEN_BG, 10'($urandom_range(1023, 1)));
    random_phase(650);
    drain();

    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/wbgc_pkg.sv
rtl/wbgc_cell.sv
rtl/wbgc_row.sv
rtl/otp_white_balance_gain_calc_top.sv
dv/tb_otp_white_balance_gain_calc_top.sv
